FILE: hw/rtl/pkf_pkg.sv
// Shared types, constants, microcode and saturation helpers of the pose filter.
package pkf_pkg;

    localparam int QW       = 48;
    localparam int ACCW     = 52;
    localparam int MAGW     = 51;
    localparam int IN_W     = 480;
    localparam int OUT_W    = 296;
    localparam int USER_W   = 2;
    localparam int UPC_W    = 6;
    localparam int WRAP_CNT = 5;

    typedef logic signed [QW-1:0]   q_t;
    typedef logic signed [ACCW-1:0] acc_t;
    typedef logic [MAGW-1:0]        mag_t;

    localparam q_t   Q_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam q_t   Q_ONE      = 48'sd16777216;
    localparam q_t   COV_INIT   = 48'sd6710886400;
    localparam q_t   FLOOR_POS  = 48'sd16777216;
    localparam q_t   FLOOR_HEAD = 48'sd17;
    localparam q_t   PI_Q       = 48'sd52707179;
    localparam acc_t TWO_PI_Q   = 52'sd105414357;
    localparam acc_t WRAP_LO    = -52'sd52707177;
    localparam acc_t WRAP_HI    = 52'sd52707177;
    localparam mag_t MAG_LIM    = mag_t'(1) << 47;

    // Operation codes carried in the request's user field.
    typedef enum logic [USER_W-1:0] {
        OP_PREDICT = 2'd0,
        OP_UPDATE  = 2'd1,
        OP_RESET   = 2'd2,
        OP_NOP     = 2'd3
    } op_t;

    // Micro-operation kinds run by the sequencer.
    typedef enum logic [2:0] {
        K_ADD,
        K_MUL,
        K_DIV,
        K_CHKS,
        K_WRAP,
        K_FLOOR,
        K_END
    } uop_kind_t;

    // Operand and destination registers of the datapath.
    typedef enum logic [4:0] {
        R_NONE, R_EST_X, R_EST_Y, R_EST_H,
        R_CXX, R_CXY, R_CXH, R_CYY, R_CYH, R_CHH,
        R_MOVE_X, R_MOVE_Y, R_NOISE_P, R_NOISE_H,
        R_JAC_X, R_JAC_Y, R_JAC_H, R_INN, R_MNOISE,
        R_PH0, R_PH1, R_PH2, R_S, R_K0, R_K1, R_K2, R_T
    } opsel_t;

    typedef struct packed {
        uop_kind_t kind;
        logic      clr;
        logic      neg;
        logic      wr;
        opsel_t    a;
        opsel_t    b;
        opsel_t    dest;
    } uop_t;

    localparam int UCODE_LEN  = 58;
    localparam int PRED_START = 0;
    localparam int UPD_START  = 21;

    // Microprogram: predict from PRED_START, scalar update from UPD_START.
    localparam uop_t UCODE [0:UCODE_LEN-1] = '{
        // Predict: position and variance sums.
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_EST_X,   R_NONE,   R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_MOVE_X,  R_NONE,   R_EST_X},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_EST_Y,   R_NONE,   R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_MOVE_Y,  R_NONE,   R_EST_Y},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXX,     R_NONE,   R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_NOISE_P, R_NONE,   R_CXX},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CYY,     R_NONE,   R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_NOISE_P, R_NONE,   R_CYY},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CHH,     R_NONE,   R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_NOISE_H, R_NONE,   R_CHH},
        // Predict: cross terms, cov_xy first while cov_xh and cov_yh are old.
        '{K_MUL, 1'b1, 1'b0, 1'b1, R_MOVE_Y,  R_MOVE_X, R_T},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXY,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_MOVE_X,  R_CXH,    R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b0, R_MOVE_Y,  R_CYH,    R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_T,       R_CHH,    R_CXY},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXH,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_MOVE_Y,  R_CHH,    R_CXH},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CYH,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_MOVE_X,  R_CHH,    R_CYH},
        '{K_WRAP, 1'b0, 1'b0, 1'b0, R_NONE,   R_NONE,   R_NONE},
        '{K_END, 1'b0, 1'b0, 1'b0, R_NONE,    R_NONE,   R_NONE},
        // Update: P times H transposed.
        '{K_MUL, 1'b1, 1'b0, 1'b0, R_JAC_X,   R_CXX,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_JAC_Y,   R_CXY,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_JAC_H,   R_CXH,    R_PH0},
        '{K_MUL, 1'b1, 1'b0, 1'b0, R_JAC_X,   R_CXY,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_JAC_Y,   R_CYY,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_JAC_H,   R_CYH,    R_PH1},
        '{K_MUL, 1'b1, 1'b0, 1'b0, R_JAC_X,   R_CXH,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_JAC_Y,   R_CYH,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_JAC_H,   R_CHH,    R_PH2},
        // Update: innovation variance.
        '{K_MUL, 1'b1, 1'b0, 1'b0, R_JAC_X,   R_PH0,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_JAC_Y,   R_PH1,    R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b0, R_JAC_H,   R_PH2,    R_NONE},
        '{K_ADD, 1'b0, 1'b0, 1'b1, R_MNOISE,  R_NONE,   R_S},
        '{K_CHKS, 1'b0, 1'b0, 1'b0, R_NONE,   R_NONE,   R_NONE},
        // Update: gains.
        '{K_DIV, 1'b0, 1'b0, 1'b1, R_PH0,     R_S,      R_K0},
        '{K_DIV, 1'b0, 1'b0, 1'b1, R_PH1,     R_S,      R_K1},
        '{K_DIV, 1'b0, 1'b0, 1'b1, R_PH2,     R_S,      R_K2},
        // Update: pose correction.
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_EST_X,   R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_K0,      R_INN,    R_EST_X},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_EST_Y,   R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_K1,      R_INN,    R_EST_Y},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_EST_H,   R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b0, 1'b1, R_K2,      R_INN,    R_EST_H},
        // Update: covariance shrink.
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXX,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K0,      R_PH0,    R_CXX},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXY,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K0,      R_PH1,    R_CXY},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CXH,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K0,      R_PH2,    R_CXH},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CYY,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K1,      R_PH1,    R_CYY},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CYH,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K1,      R_PH2,    R_CYH},
        '{K_ADD, 1'b1, 1'b0, 1'b0, R_CHH,     R_NONE,   R_NONE},
        '{K_MUL, 1'b0, 1'b1, 1'b1, R_K2,      R_PH2,    R_CHH},
        '{K_FLOOR, 1'b0, 1'b0, 1'b0, R_NONE,  R_NONE,   R_NONE},
        '{K_END, 1'b0, 1'b0, 1'b0, R_NONE,    R_NONE,   R_NONE}
    };

    // Saturate a wide sum to the 48-bit range.
    function automatic q_t sat_acc(input acc_t v);
        if (v > acc_t'(Q_MAX)) begin
            return Q_MAX;
        end
        if (v < acc_t'(~Q_MAX)) begin
            return ~Q_MAX;
        end
        return v[QW-1:0];
    endfunction

    // Apply a sign to a magnitude, clamping to the 48-bit range.
    function automatic q_t sign_mag(input mag_t mag, input logic neg);
        logic [QW-1:0] m;
        m = (mag > MAG_LIM) ? MAG_LIM[QW-1:0] : mag[QW-1:0];
        if (neg) begin
            return q_t'(~m + 48'd1);
        end
        if (m > Q_MAX) begin
            return Q_MAX;
        end
        return q_t'(m);
    endfunction

    // Magnitude of a signed value; the most negative value maps to 2^47.
    function automatic logic [QW-1:0] mag_of(input q_t v);
        return v[QW-1] ? (~v + 48'd1) : v;
    endfunction

endpackage

FILE: hw/rtl/pkf_qmul.sv
// Q24.24 multiplier built from one shared 24x24 multiplier, stepped through the partial products.
module pkf_qmul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  pkf_pkg::q_t a,
    input  pkf_pkg::q_t b,
    output logic        busy,
    output logic        done,
    output pkf_pkg::q_t p
);
    import pkf_pkg::*;

    logic [QW-1:0] ua_reg;
    logic [QW-1:0] ub_reg;
    logic          neg_reg;
    logic [1:0]    step_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [49:0]   mid_reg;
    q_t            p_reg;
    logic [23:0]   mx;
    logic [23:0]   my;
    logic [47:0]   prod;
    mag_t          mag;

    // Pick the partial product for this step.
    always_comb
    begin
        unique case (step_reg)
            2'd0:    begin mx = ua_reg[23:0];  my = ub_reg[23:0];  end
            2'd1:    begin mx = ua_reg[47:24]; my = ub_reg[23:0];  end
            2'd2:    begin mx = ua_reg[23:0];  my = ub_reg[47:24]; end
            default: begin mx = ua_reg[47:24]; my = ub_reg[47:24]; end
        endcase
        prod = mx * my;
        mag  = (prod >= 48'd8388608) ? MAG_LIM
             : mag_t'({prod[22:0], 24'd0}) + mag_t'(mid_reg);
    end

    // Step through the partial products and round the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ua_reg   <= mag_of(a);
                ub_reg   <= mag_of(b);
                neg_reg  <= a[QW-1] ^ b[QW-1];
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                step_reg <= step_reg + 2'd1;
                unique case (step_reg)
                    2'd0: mid_reg <= 50'((49'(prod) + 49'd8388608) >> 24);
                    2'd1: mid_reg <= mid_reg + 50'(prod);
                    2'd2: mid_reg <= mid_reg + 50'(prod);
                    default:
                    begin
                        p_reg    <= sign_mag(mag, neg_reg);
                        done_reg <= 1'b1;
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign p    = p_reg;

endmodule

FILE: hw/rtl/pkf_qdiv.sv
// Q24.24 divider by a positive divisor, one quotient bit per cycle.
module pkf_qdiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  pkf_pkg::q_t a,
    input  pkf_pkg::q_t s,
    output logic        done,
    output pkf_pkg::q_t q
);
    import pkf_pkg::*;

    logic [QW-1:0] rem_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] us_reg;
    logic          neg_reg;
    logic [5:0]    cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    q_t            q_reg;
    logic [QW-1:0] ua;
    logic          too_big;
    logic [QW-1:0] rem2;
    logic          take;
    logic [QW-1:0] quo_new;

    // Overflow test and one restoring step.
    always_comb
    begin
        ua      = mag_of(a);
        too_big = {23'd0, ua} >= {s, 23'd0};
        rem2    = {rem_reg[QW-2:0], low_reg[QW-1]};
        take    = rem2 >= us_reg;
        quo_new = {quo_reg[QW-2:0], take};
    end

    // Quotient of a times 2^25 over s; final bit rounds half away from zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                neg_reg <= a[QW-1];
                us_reg  <= s;
                rem_reg <= QW'(ua[47:23]);
                low_reg <= {ua[22:0], 25'd0};
                quo_reg <= '0;
                cnt_reg <= 6'd48;
                if (too_big) begin
                    q_reg    <= sign_mag(MAG_LIM, a[QW-1]);
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= take ? rem2 - us_reg : rem2;
                low_reg <= {low_reg[QW-2:0], 1'b0};
                quo_reg <= quo_new;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    q_reg    <= sign_mag(mag_t'((49'(quo_new) + 49'd1) >> 1), neg_reg);
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

FILE: hw/rtl/pose_kalman_filter_3state_top.sv
// Pose filter top level: microcoded sequencer, register file and heading wrap.
//
//  Channel  Direction  Signals                    Contents
//  s        in         s_tvalid/s_tready          s_tuser: operation; s_tdata: motion,
//                      s_tdata[479:0] s_tuser[1:0]  noise, Jacobian, innovation
//  m        out        m_tvalid/m_tready          m_tdata: pose, variances, applied
//                      m_tdata[295:0]
//
// A predict request and a scalar update run their microprogram on the shared multiplier
// and divider, which set how long each takes; a skipped update ends at the variance check,
// and reset and no-op requests go straight to the done state.
// Reset clears the estimate to its initial pose and covariance at once.
// s_tready is high only while the sequencer is idle; a result waits in the output
// register while the next request is taken, and the sequencer stalls until it is free.
module pose_kalman_filter_3state_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // move_x, move_y, move_heading, noise_position, noise_heading,
    // jac_x, jac_y, jac_heading, innovation, meas_noise, zero pad
    input  logic [pkf_pkg::IN_W-1:0]     s_tdata,
    // operation
    input  logic [pkf_pkg::USER_W-1:0]   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // pos_x, pos_y, heading, var_x, var_y, var_heading, applied, zero pad
    output logic [pkf_pkg::OUT_W-1:0]    m_tdata
);
    import pkf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_WRAP,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [UPC_W-1:0]     upc_reg;
    acc_t                 acc_reg;
    logic                 applied_reg;
    logic                 m_valid_reg;
    logic [OUT_W-1:0]     m_data_reg;

    // Filter state.
    q_t est_x_reg, est_y_reg, est_h_reg;
    q_t cxx_reg, cxy_reg, cxh_reg, cyy_reg, cyh_reg, chh_reg;
    // Request fields and temporaries.
    q_t move_x_reg, move_y_reg, move_h_reg, noise_p_reg, noise_h_reg;
    q_t jac_x_reg, jac_y_reg, jac_h_reg, inn_reg, mnoise_reg;
    q_t ph0_reg, ph1_reg, ph2_reg, s_reg, k0_reg, k1_reg, k2_reg, t_reg;

    // Heading wrap loop.
    acc_t                 h_reg;
    acc_t                 step_reg;
    logic [WRAP_CNT-1:0]  wcnt_reg;
    logic                 wdn_reg;
    logic                 wup_reg;

    uop_t                 uop;
    q_t                   opa;
    q_t                   opb;
    acc_t                 base;
    acc_t                 term;
    acc_t                 sum;
    logic                 wb_en;
    q_t                   wb_val;
    acc_t                 cand_dn;
    acc_t                 cand_up;
    acc_t                 h_new;
    acc_t                 h_start;
    logic                 mul_start;
    logic                 mul_busy;
    logic                 mul_done;
    q_t                   mul_p;
    logic                 div_start;
    logic                 div_done;
    q_t                   div_q;
    logic                 s_fire;
    logic                 out_free;

    // Register file read port.
    function automatic q_t fetch(input opsel_t sel);
        unique case (sel)
            R_EST_X:   return est_x_reg;
            R_EST_Y:   return est_y_reg;
            R_EST_H:   return est_h_reg;
            R_CXX:     return cxx_reg;
            R_CXY:     return cxy_reg;
            R_CXH:     return cxh_reg;
            R_CYY:     return cyy_reg;
            R_CYH:     return cyh_reg;
            R_CHH:     return chh_reg;
            R_MOVE_X:  return move_x_reg;
            R_MOVE_Y:  return move_y_reg;
            R_NOISE_P: return noise_p_reg;
            R_NOISE_H: return noise_h_reg;
            R_JAC_X:   return jac_x_reg;
            R_JAC_Y:   return jac_y_reg;
            R_JAC_H:   return jac_h_reg;
            R_INN:     return inn_reg;
            R_MNOISE:  return mnoise_reg;
            R_PH0:     return ph0_reg;
            R_PH1:     return ph1_reg;
            R_PH2:     return ph2_reg;
            R_S:       return s_reg;
            R_K0:      return k0_reg;
            R_K1:      return k1_reg;
            R_K2:      return k2_reg;
            R_T:       return t_reg;
            default:   return '0;
        endcase
    endfunction

    // Shared datapath: operand fetch, accumulate and write-back value.
    always_comb
    begin
        uop      = UCODE[upc_reg];
        opa      = fetch(uop.a);
        opb      = fetch(uop.b);
        base     = uop.clr ? '0 : acc_reg;
        term     = (uop.kind == K_MUL) ? acc_t'(mul_p) : acc_t'(opa);
        sum      = uop.neg ? base - term : base + term;
        wb_en    = ((state_reg == ST_EXEC) && (uop.kind == K_ADD) && uop.wr)
                || ((state_reg == ST_MUL) && mul_done && uop.wr)
                || ((state_reg == ST_DIV) && div_done);
        wb_val   = (state_reg == ST_DIV) ? div_q : sat_acc(sum);
        mul_start = (state_reg == ST_EXEC) && (uop.kind == K_MUL);
        div_start = (state_reg == ST_EXEC) && (uop.kind == K_DIV);
        s_fire   = s_tvalid && s_tready;
        out_free = !m_valid_reg || m_tready;
    end

    // Heading wrap: greedy removal of multiples of two pi.
    always_comb
    begin
        h_start = acc_t'(est_h_reg) + acc_t'(move_h_reg);
        cand_dn = h_reg - step_reg;
        cand_up = h_reg + step_reg;
        if (wdn_reg && (cand_dn >= WRAP_LO)) begin
            h_new = cand_dn;
        end else if (wup_reg && (cand_up <= WRAP_HI)) begin
            h_new = cand_up;
        end else begin
            h_new = h_reg;
        end
    end

    pkf_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .busy  (mul_busy),
        .done  (mul_done),
        .p     (mul_p)
    );

    pkf_qdiv u_qdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (opa),
        .s     (opb),
        .done  (div_done),
        .q     (div_q)
    );

    // Sequencer, filter state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            upc_reg     <= '0;
            applied_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            est_x_reg   <= '0;
            est_y_reg   <= '0;
            est_h_reg   <= '0;
            cxx_reg     <= COV_INIT;
            cxy_reg     <= '0;
            cxh_reg     <= '0;
            cyy_reg     <= COV_INIT;
            cyh_reg     <= '0;
            chh_reg     <= Q_ONE;
        end else begin
            // Drop a taken result unless the done state loads the next one.
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end

            // Write-back from the shared units.
            if (wb_en) begin
                unique case (uop.dest)
                    R_EST_X: est_x_reg <= wb_val;
                    R_EST_Y: est_y_reg <= wb_val;
                    R_EST_H: est_h_reg <= wb_val;
                    R_CXX:   cxx_reg   <= wb_val;
                    R_CXY:   cxy_reg   <= wb_val;
                    R_CXH:   cxh_reg   <= wb_val;
                    R_CYY:   cyy_reg   <= wb_val;
                    R_CYH:   cyh_reg   <= wb_val;
                    R_CHH:   chh_reg   <= wb_val;
                    R_PH0:   ph0_reg   <= wb_val;
                    R_PH1:   ph1_reg   <= wb_val;
                    R_PH2:   ph2_reg   <= wb_val;
                    R_S:     s_reg     <= wb_val;
                    R_K0:    k0_reg    <= wb_val;
                    R_K1:    k1_reg    <= wb_val;
                    R_K2:    k2_reg    <= wb_val;
                    R_T:     t_reg     <= wb_val;
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire) begin
                        move_x_reg  <= s_tdata[47:0];
                        move_y_reg  <= s_tdata[95:48];
                        move_h_reg  <= s_tdata[143:96];
                        noise_p_reg <= {1'b0, s_tdata[190:144]};
                        noise_h_reg <= {1'b0, s_tdata[237:191]};
                        jac_x_reg   <= s_tdata[285:238];
                        jac_y_reg   <= s_tdata[333:286];
                        jac_h_reg   <= s_tdata[381:334];
                        inn_reg     <= s_tdata[429:382];
                        mnoise_reg  <= {1'b0, s_tdata[476:430]};
                        unique case (op_t'(s_tuser))
                            OP_PREDICT:
                            begin
                                upc_reg   <= UPC_W'(PRED_START);
                                state_reg <= ST_EXEC;
                            end
                            OP_UPDATE:
                            begin
                                upc_reg   <= UPC_W'(UPD_START);
                                state_reg <= ST_EXEC;
                            end
                            OP_RESET:
                            begin
                                est_x_reg   <= '0;
                                est_y_reg   <= '0;
                                est_h_reg   <= '0;
                                cxx_reg     <= COV_INIT;
                                cxy_reg     <= '0;
                                cxh_reg     <= '0;
                                cyy_reg     <= COV_INIT;
                                cyh_reg     <= '0;
                                chh_reg     <= Q_ONE;
                                applied_reg <= 1'b1;
                                state_reg   <= ST_DONE;
                            end
                            default:
                            begin
                                applied_reg <= 1'b0;
                                state_reg   <= ST_DONE;
                            end
                        endcase
                    end
                end

                ST_EXEC:
                begin
                    unique case (uop.kind)
                        K_ADD:
                        begin
                            acc_reg <= sum;
                            upc_reg <= upc_reg + UPC_W'(1);
                        end
                        K_MUL:   state_reg <= ST_MUL;
                        K_DIV:   state_reg <= ST_DIV;
                        K_CHKS:
                        begin
                            if (s_reg <= 48'sd0) begin
                                applied_reg <= 1'b0;
                                state_reg   <= ST_DONE;
                            end else begin
                                upc_reg <= upc_reg + UPC_W'(1);
                            end
                        end
                        K_WRAP:
                        begin
                            h_reg     <= h_start;
                            step_reg  <= TWO_PI_Q <<< 22;
                            wcnt_reg  <= WRAP_CNT'(22);
                            wdn_reg   <= h_start > acc_t'(PI_Q);
                            wup_reg   <= h_start < -acc_t'(PI_Q);
                            state_reg <= ST_WRAP;
                        end
                        K_FLOOR:
                        begin
                            if (cxx_reg < FLOOR_POS) begin
                                cxx_reg <= FLOOR_POS;
                            end
                            if (cyy_reg < FLOOR_POS) begin
                                cyy_reg <= FLOOR_POS;
                            end
                            if (chh_reg < FLOOR_HEAD) begin
                                chh_reg <= FLOOR_HEAD;
                            end
                            upc_reg <= upc_reg + UPC_W'(1);
                        end
                        default:
                        begin
                            applied_reg <= 1'b1;
                            state_reg   <= ST_DONE;
                        end
                    endcase
                end

                ST_MUL:
                begin
                    if (mul_done) begin
                        acc_reg   <= sum;
                        upc_reg   <= upc_reg + UPC_W'(1);
                        state_reg <= ST_EXEC;
                    end
                end

                ST_DIV:
                begin
                    if (div_done) begin
                        upc_reg   <= upc_reg + UPC_W'(1);
                        state_reg <= ST_EXEC;
                    end
                end

                ST_WRAP:
                begin
                    h_reg    <= h_new;
                    step_reg <= step_reg >>> 1;
                    wcnt_reg <= wcnt_reg - WRAP_CNT'(1);
                    if (wcnt_reg == '0) begin
                        est_h_reg <= h_new[QW-1:0];
                        upc_reg   <= upc_reg + UPC_W'(1);
                        state_reg <= ST_EXEC;
                    end
                end

                default:
                begin
                    // Hand the snapshot to the output register once it is free.
                    if (out_free) begin
                        m_data_reg  <= {7'd0, applied_reg, chh_reg, cyy_reg, cxx_reg,
                                        est_h_reg, est_y_reg, est_x_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // The multiplier is never restarted while a product is in flight.
    assert property (@(posedge clk) disable iff (!rst_n) mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // The wrapped heading lies within plus or minus pi.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRAP && wcnt_reg == '0)
        |=> (est_h_reg <= PI_Q && est_h_reg >= -PI_Q))
        else $error("heading outside wrap range");

    // Variances respect their floors after an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && uop.kind == K_FLOOR)
        |=> (cxx_reg >= FLOOR_POS && cyy_reg >= FLOOR_POS && chh_reg >= FLOOR_HEAD))
        else $error("variance below floor");
`endif

endmodule
